FILE: hdl/polygon_point_and_border_test_core_macros.svh
// Assertion macros shared by the polygon point and border test RTL.
`ifndef POLYGON_POINT_AND_BORDER_TEST_CORE_MACROS_SVH
`define POLYGON_POINT_AND_BORDER_TEST_CORE_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define PPBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Check that a condition implies another one in the next cycle.
`define PPBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

FILE: hdl/ppbt_pkg.sv
// Package with widths, codes, reset values and types of the polygon test core.
package ppbt_pkg;

	// Default sizes of the vertex table and the coordinates
	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_BITS_DEF   = 32;

	// Fixed field widths
	localparam int COUNT_W   = 5;
	localparam int SLOT_W    = 4;
	localparam int HEIGHT_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAX   = 2'd2;

	// Reset values of the height band, Q25.6 (minus 64 and 320)
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN_RST = -32'sd4096;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX_RST = 32'sd20480;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Control that travels with one edge down the crossing pipeline
	typedef struct packed {
		logic vld;
		logic span;
		logic last;
		logic dzpos;
	} edge_ctl_t;

endpackage

FILE: hdl/ppbt_if.sv
// Handshake interfaces for the query and result channels.
interface ppbt_in_if #(
	parameter int COORD_BITS = ppbt_pkg::COORD_BITS_DEF
);
	import ppbt_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [SLOT_W-1:0]            vertex_slot;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_z;
	logic signed [HEIGHT_W-1:0]   coord_y;

	modport source (
		output valid, operation, vertex_slot, coord_x, coord_z, coord_y,
		input  ready
	);
	modport sink (
		input  valid, operation, vertex_slot, coord_x, coord_z, coord_y,
		output ready
	);
endinterface

interface ppbt_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic on_border;

	modport source (
		output valid, inside_res, on_border,
		input  ready
	);
	modport sink (
		input  valid, inside_res, on_border,
		output ready
	);
endinterface

FILE: hdl/polygon_point_and_border_test_core.sv
// Point-in-polygon and border test core with a vertex memory and an edge pipeline.
//
// Channel   Dir   Word
// query     in    operation, vertex_slot, coord_x, coord_z, coord_y
// result    out   inside_res, on_border (one word per point test)
// cfg       in    cfg_wen, cfg_index, cfg_data (vertex_count, height_min, height_max)
//
// A point test on n vertices in use makes one memory read per vertex, then feeds
// the closing edge and three stages of cross-multiplication; out-of-band heights
// and an empty table skip the reads and go straight to the result.
// The single read port of the vertex memory sets the one-edge-per-cycle pace.
// Reset clears control and configuration; the vertex memory holds no reset value.
// A held result stalls only the hand-off from the pending result register.
module polygon_point_and_border_test_core #(
	parameter int MAX_VERTICES = ppbt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = ppbt_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ppbt_in_if.sink                            query,
	ppbt_out_if.source                         result,
	input  logic                               cfg_wen,
	input  logic [ppbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ppbt_pkg::*;

	`include "polygon_point_and_border_test_core_macros.svh"

	localparam int W      = COORD_BITS;
	localparam int D      = COORD_BITS + 1;
	localparam int H      = D / 2;
	localparam int P_W    = D + H + 1;
	localparam int F_W    = 2 * D;
	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int N_W    = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W  = (N_W > COUNT_W) ? N_W : COUNT_W;
	localparam int SCMP_W = (N_W > SLOT_W) ? N_W : SLOT_W;

	// Configuration registers
	logic [COUNT_W-1:0]         vertex_count_q;
	logic signed [HEIGHT_W-1:0] height_min_q;
	logic signed [HEIGHT_W-1:0] height_max_q;

	// Sequencer
	state_t             state_q;
	logic [IDX_W-1:0]   rd_cnt_q;
	logic               rd_vld_q;
	logic               rd_first_q;
	logic               rd_last_q;
	logic               close_q;
	logic               parity_q;
	logic               border_q;
	logic               res_inside_q;
	logic               res_border_q;
	logic               out_vld_q;
	logic               out_inside_q;
	logic               out_border_q;

	// Vertex memory, x in the upper half, z in the lower half
	logic [2*W-1:0]     vtx_mem_q [MAX_VERTICES];
	logic [2*W-1:0]     rdata_q;

	// Point and vertex holding registers
	logic signed [W-1:0] px_q, pz_q;
	logic signed [W-1:0] first_x_q, first_z_q;
	logic signed [W-1:0] prev_x_q, prev_z_q;

	// Edge pipeline
	edge_ctl_t           ctl_d, ctl_s1, ctl_s2, ctl_s3;
	logic signed [D-1:0] a1_s1, dz_s1, b2_s1, c2_s1;
	logic signed [P_W-1:0] pl_lhs_s2, ph_lhs_s2, pl_rhs_s2, ph_rhs_s2;
	logic signed [F_W-1:0] lhs_s3, rhs_s3;

	logic                accept;
	logic                out_band;
	logic [CMP_W-1:0]    n_cnt;
	logic                n_zero;
	logic [IDX_W-1:0]    last_idx;
	logic                slot_ok;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_idx;

	logic signed [W-1:0] rd_x, rd_z, cur_x, cur_z;
	logic signed [D-1:0] a1_d, dz_d, b2_d, c2_d;
	logic                x_in, z_in, vert, horiz, hit;
	logic signed [H:0]   dz_lo, c2_lo;
	logic signed [D-H-1:0] dz_hi, c2_hi;
	logic signed [P_W-1:0] pl_lhs_d, ph_lhs_d, pl_rhs_d, ph_rhs_d;
	logic signed [F_W-1:0] lhs_d, rhs_d;
	logic                left, toggle, edge_done, out_free;

	// Decode the query handshake, height band and vertex count
	assign accept   = query.valid && query.ready;
	assign out_band = (query.coord_y < height_min_q) || (query.coord_y > height_max_q);
	assign n_cnt    = (CMP_W'(vertex_count_q) > CMP_W'(MAX_VERTICES)) ?
	                  CMP_W'(MAX_VERTICES) : CMP_W'(vertex_count_q);
	assign n_zero   = (n_cnt == '0);
	assign last_idx = IDX_W'(n_cnt - CMP_W'(1));
	assign slot_ok  = (SCMP_W'(query.vertex_slot) < SCMP_W'(MAX_VERTICES));
	assign wr_idx   = IDX_W'(query.vertex_slot);
	assign mem_we   = accept && (query.operation == OP_WRITE) && slot_ok;

	assign query.ready = (state_q == ST_IDLE);
	assign out_free    = !out_vld_q || result.ready;

	// Store vertices and read one entry per cycle during a test
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vtx_mem_q[wr_idx] <= {query.coord_x, query.coord_z};
		end
		if (state_q == ST_READ) begin
			rdata_q <= vtx_mem_q[rd_cnt_q];
		end
	end

	assign rd_x = rdata_q[2*W-1:W];
	assign rd_z = rdata_q[W-1:0];

	// Form the current edge and its differences
	always_comb begin
		cur_x  = close_q ? first_x_q : rd_x;
		cur_z  = close_q ? first_z_q : rd_z;
		dz_d   = D'(prev_z_q) - D'(cur_z);
		a1_d   = D'(px_q) - D'(cur_x);
		b2_d   = D'(prev_x_q) - D'(cur_x);
		c2_d   = D'(pz_q) - D'(cur_z);
		ctl_d.vld   = (rd_vld_q && !rd_first_q) || close_q;
		ctl_d.span  = ((cur_z <= pz_q) && (pz_q < prev_z_q)) ||
		              ((prev_z_q <= pz_q) && (pz_q < cur_z));
		ctl_d.last  = close_q;
		ctl_d.dzpos = !dz_d[D-1] && (dz_d != '0);
		x_in  = ((px_q >= prev_x_q) && (px_q <= cur_x)) ||
		        ((px_q >= cur_x) && (px_q <= prev_x_q));
		z_in  = ((pz_q >= prev_z_q) && (pz_q <= cur_z)) ||
		        ((pz_q >= cur_z) && (pz_q <= prev_z_q));
		vert  = (prev_x_q == cur_x);
		horiz = (prev_z_q == cur_z);
		hit   = rd_vld_q && !rd_first_q &&
		        ((vert && (px_q == cur_x) && z_in) ||
		         (!vert && horiz && (pz_q == cur_z) && x_in));
	end

	// Split the second factors into an unsigned low half and a signed high half
	assign dz_lo = $signed({1'b0, dz_s1[H-1:0]});
	assign dz_hi = $signed(dz_s1[D-1:H]);
	assign c2_lo = $signed({1'b0, c2_s1[H-1:0]});
	assign c2_hi = $signed(c2_s1[D-1:H]);

	assign pl_lhs_d = a1_s1 * dz_lo;
	assign ph_lhs_d = a1_s1 * dz_hi;
	assign pl_rhs_d = b2_s1 * c2_lo;
	assign ph_rhs_d = b2_s1 * c2_hi;

	// Recombine partial products into exact cross products
	assign lhs_d = F_W'(pl_lhs_s2) + (F_W'(ph_lhs_s2) <<< H);
	assign rhs_d = F_W'(pl_rhs_s2) + (F_W'(ph_rhs_s2) <<< H);

	// Decide the crossing and retire the closing edge
	assign left      = ctl_s3.dzpos ? (lhs_s3 < rhs_s3) : (rhs_s3 < lhs_s3);
	assign toggle    = ctl_s3.vld && ctl_s3.span && left;
	assign edge_done = ctl_s3.vld && ctl_s3.last;

	// Advance the edge pipeline data
	always_ff @(posedge clk) begin
		a1_s1     <= a1_d;
		dz_s1     <= dz_d;
		b2_s1     <= b2_d;
		c2_s1     <= c2_d;
		pl_lhs_s2 <= pl_lhs_d;
		ph_lhs_s2 <= ph_lhs_d;
		pl_rhs_s2 <= pl_rhs_d;
		ph_rhs_s2 <= ph_rhs_d;
		lhs_s3    <= lhs_d;
		rhs_s3    <= rhs_d;
	end

	// Hold the point and track the first and previous vertex
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= query.coord_x;
			pz_q <= query.coord_z;
		end
		if (rd_vld_q) begin
			prev_x_q <= rd_x;
			prev_z_q <= rd_z;
		end
		if (rd_vld_q && rd_first_q) begin
			first_x_q <= rd_x;
			first_z_q <= rd_z;
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			height_min_q   <= HEIGHT_MIN_RST;
			height_max_q   <= HEIGHT_MAX_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT: vertex_count_q <= cfg_data[COUNT_W-1:0];
				CFG_HEIGHT_MIN:   height_min_q   <= $signed(cfg_data[HEIGHT_W-1:0]);
				CFG_HEIGHT_MAX:   height_max_q   <= $signed(cfg_data[HEIGHT_W-1:0]);
				default: ;
			endcase
		end
	end

	// Sequence reads, accumulate parity and border, hand off results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			rd_vld_q     <= 1'b0;
			rd_first_q   <= 1'b0;
			rd_last_q    <= 1'b0;
			close_q      <= 1'b0;
			parity_q     <= 1'b0;
			border_q     <= 1'b0;
			res_inside_q <= 1'b0;
			res_border_q <= 1'b0;
			out_vld_q    <= 1'b0;
			out_inside_q <= 1'b0;
			out_border_q <= 1'b0;
			ctl_s1       <= '0;
			ctl_s2       <= '0;
			ctl_s3       <= '0;
		end else begin
			rd_vld_q   <= (state_q == ST_READ);
			rd_first_q <= (state_q == ST_READ) && (rd_cnt_q == '0);
			rd_last_q  <= (state_q == ST_READ) && (rd_cnt_q == last_idx);
			close_q    <= rd_vld_q && rd_last_q;
			ctl_s1     <= ctl_d;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;

			// Clear the accumulators while idle, else fold in each edge
			if (state_q == ST_IDLE) begin
				parity_q <= 1'b0;
				border_q <= 1'b0;
			end else begin
				parity_q <= parity_q ^ toggle;
				if (hit) begin
					border_q <= 1'b1;
				end
			end

			// Load the output register on hand-off, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (query.operation == OP_TEST)) begin
						if (out_band || n_zero) begin
							res_inside_q <= 1'b0;
							res_border_q <= 1'b0;
							state_q      <= ST_DONE;
						end else begin
							rd_cnt_q <= '0;
							state_q  <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (rd_cnt_q == last_idx) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (edge_done) begin
						res_inside_q <= parity_q ^ toggle;
						res_border_q <= border_q;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_inside_q <= res_inside_q;
						out_border_q <= res_border_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid      = out_vld_q;
	assign result.inside_res = out_inside_q;
	assign result.on_border  = out_border_q;

	// Reads never run past the last vertex in use
	`PPBT_ASSERT_SAME(a_rd_in_range, clk, arst_n, state_q == ST_READ, rd_cnt_q <= last_idx)
	// The edge pipeline is empty whenever a new word can be taken
	`PPBT_ASSERT_SAME(a_pipe_empty, clk, arst_n, state_q == ST_IDLE,
		!(ctl_s1.vld || ctl_s2.vld || ctl_s3.vld || rd_vld_q || close_q))
	// The closing edge retires only while draining
	`PPBT_ASSERT_SAME(a_done_drain, clk, arst_n, edge_done, state_q == ST_DRAIN)
	// A finished result reaches the output register on hand-off
	`PPBT_ASSERT_NEXT(a_handoff, clk, arst_n, (state_q == ST_DONE) && out_free,
		out_vld_q && (state_q == ST_IDLE))

endmodule

FILE: tb/tb_polygon_point_and_border_test_core.sv
// Self-checking testbench of the polygon point and border test core.
module tb_polygon_point_and_border_test_core;
	import ppbt_pkg::*;

	localparam int MAXV        = MAX_VERTICES_DEF;
	localparam int CW          = COORD_BITS_DEF;
	localparam int WORD_GOAL   = 1850;
	localparam int SETTLE      = MAXV + 16;
	localparam int STALL_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [31:0] C_MIN = 32'h8000_0000;
	localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic inside_res;
		logic on_border;
	} answer_t;

	// One line of the directed sequence: a register write or a query word
	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]          reg_data;
		logic                 op;
		logic [SLOT_W-1:0]    slot;
		logic [31:0]          x;
		logic [31:0]          z;
		logic [31:0]          y;
		bit                   fixed;
		answer_t              fixed_ans;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppbt_in_if #(.COORD_BITS(CW)) query_if ();
	ppbt_out_if                   result_if ();

	polygon_point_and_border_test_core #(
		.MAX_VERTICES(MAXV),
		.COORD_BITS  (CW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (query_if),
		.result   (result_if),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the vertex table and the registers
	longint             vtx_x [MAXV];
	longint             vtx_z [MAXV];
	logic [COUNT_W-1:0] poly_count;
	logic signed [31:0] band_lo;
	logic signed [31:0] band_hi;

	answer_t   pending_answers [$];
	stim_row_t dir_rows [$];

	int errors = 0;
	int words_sent = 0;
	int tests_sent = 0;
	int reg_writes = 0;
	int results_seen = 0;
	int inside_hits = 0;
	int border_hits = 0;
	int quiet_cycles = 0;
	bit busy = 1'b0;
	bit calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint rand_between(longint lo, longint hi);
		logic [63:0] span;
		logic [63:0] pick;
		span = 64'(hi - lo) + 64'd1;
		pick = {$urandom(), $urandom()};
		return lo + longint'(pick % span);
	endfunction

	function automatic longint pick_extreme();
		case ($urandom_range(0, 5))
			0: return sx(C_MIN);
			1: return sx(C_MAX);
			2: return longint'(0);
			3: return longint'(-1);
			4: return longint'(1);
			default: return sx($urandom());
		endcase
	endfunction

	// Crossing-number parity: each vertex paired with its cyclic predecessor
	function automatic logic ray_parity(longint cx, longint cz, int n);
		logic               odd;
		int                 j;
		longint             xi, zi, xj, zj, dz;
		logic signed [127:0] fa, fb, lhs, rhs;
		odd = 1'b0;
		if (n == 0)
			return 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = vtx_x[i];
			zi = vtx_z[i];
			xj = vtx_x[j];
			zj = vtx_z[j];
			if ((zi <= cz && cz < zj) || (zj <= cz && cz < zi)) begin
				dz = zj - zi;
				fa = 128'(cx - xi);
				fb = 128'(dz);
				lhs = fa * fb;
				fa = 128'(xj - xi);
				fb = 128'(cz - zi);
				rhs = fa * fb;
				if ((dz > 0) ? (lhs < rhs) : (rhs < lhs))
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	// Border: consecutive pairs only, axis-aligned edges only
	function automatic logic touches_border(longint cx, longint cz, int n);
		longint x1, z1, x2, z2;
		for (int i = 0; i + 1 < n; i++) begin
			x1 = vtx_x[i];
			z1 = vtx_z[i];
			x2 = vtx_x[i + 1];
			z2 = vtx_z[i + 1];
			if (cx >= ((x1 < x2) ? x1 : x2) && cx <= ((x1 < x2) ? x2 : x1) &&
			    cz >= ((z1 < z2) ? z1 : z2) && cz <= ((z1 < z2) ? z2 : z1)) begin
				if (x1 == x2) begin
					if (cx == x1)
						return 1'b1;
				end else if (z1 == z2) begin
					if (cz == z1)
						return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic answer_t judge_point(logic [31:0] x, logic [31:0] z, logic [31:0] y);
		answer_t verdict;
		int      n;
		n = (poly_count > MAXV) ? MAXV : int'(poly_count);
		verdict = '0;
		if ($signed(y) >= band_lo && $signed(y) <= band_hi) begin
			verdict.inside_res = ray_parity(sx(x), sx(z), n);
			verdict.on_border  = touches_border(sx(x), sx(z), n);
		end
		return verdict;
	endfunction

	function automatic stim_row_t wr_row(int slot, logic [31:0] x, logic [31:0] z);
		stim_row_t row;
		row = '{default: '0};
		row.op = OP_WRITE;
		row.slot = SLOT_W'(slot);
		row.x = x;
		row.z = z;
		row.y = $urandom();
		return row;
	endfunction

	function automatic stim_row_t pt_row(logic [31:0] x, logic [31:0] z, logic [31:0] y);
		stim_row_t row;
		row = '{default: '0};
		row.op = OP_TEST;
		row.slot = SLOT_W'($urandom_range(0, MAXV - 1));
		row.x = x;
		row.z = z;
		row.y = y;
		return row;
	endfunction

	function automatic stim_row_t pt_fixed_row(logic [31:0] x, logic [31:0] z,
			logic [31:0] y, answer_t ans);
		stim_row_t row;
		row = pt_row(x, z, y);
		row.fixed = 1'b1;
		row.fixed_ans = ans;
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		stim_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		return row;
	endfunction

	// Append one row to the directed sequence
	function automatic void add_row(stim_row_t row);
		dir_rows = {dir_rows, row};
	endfunction

	// Present one word after a random gap, hold it until taken, then predict
	task automatic send_word(logic op, logic [SLOT_W-1:0] slot, logic [31:0] x,
			logic [31:0] z, logic [31:0] y, bit fixed, answer_t fixed_ans);
		int      gap;
		answer_t ans;
		gap = pick_gap();
		if (gap > 0) begin
			query_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_if.valid       <= 1'b1;
		query_if.operation   <= op;
		query_if.vertex_slot <= slot;
		query_if.coord_x     <= x;
		query_if.coord_z     <= z;
		query_if.coord_y     <= y;
		@(posedge clk);
		while (!query_if.ready)
			@(posedge clk);
		busy = 1'b1;
		words_sent++;
		if (op == OP_WRITE) begin
			vtx_x[slot] = sx(x);
			vtx_z[slot] = sx(z);
		end else begin
			tests_sent++;
			ans = fixed ? fixed_ans : judge_point(x, z, y);
			pending_answers = {pending_answers, ans};
		end
	endtask

	// Drop valid, drain outstanding results and let the table settle
	task automatic wait_idle();
		query_if.valid <= 1'b0;
		if (busy) begin
			while (pending_answers.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
			busy = 1'b0;
		end
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_VERTEX_COUNT: poly_count = data[COUNT_W-1:0];
			CFG_HEIGHT_MIN:   band_lo = data;
			CFG_HEIGHT_MAX:   band_hi = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result side: random stalls on ready
	initial begin : result_pacing
		int stall_left;
		stall_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			end
		end
	end

	// Compare each result word with the oldest expected answer
	always @(posedge clk) begin : check_results
		answer_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				$error("result word with no point test waiting");
				errors++;
			end else begin
				want = pending_answers.pop_front();
				inside_hits += int'(want.inside_res);
				border_hits += int'(want.on_border);
				if (result_if.inside_res !== want.inside_res) begin
					$error("inside_res: expected %0b, got %0b",
						want.inside_res, result_if.inside_res);
					errors++;
				end
				if (result_if.on_border !== want.on_border) begin
					$error("on_border: expected %0b, got %0b",
						want.on_border, result_if.on_border);
					errors++;
				end
			end
		end
	end

	// Abort when no word moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (query_if.valid && query_if.ready) ||
		    (result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int          r, cnt, n, nq, style, pi, pj, off;
		longint      step, ox, oz, ax, az, x1, z1, x2, z2, lo_x, hi_x, lo_z, hi_z;
		longint      poly_x [MAXV];
		longint      poly_z [MAXV];
		logic [31:0] data, hlo, hhi;

		query_if.valid       <= 1'b0;
		query_if.operation   <= OP_WRITE;
		query_if.vertex_slot <= '0;
		query_if.coord_x     <= '0;
		query_if.coord_z     <= '0;
		query_if.coord_y     <= '0;
		cfg_wen   <= 1'b0;
		cfg_index <= CFG_VERTEX_COUNT;
		cfg_data  <= '0;
		poly_count = '0;
		band_lo = HEIGHT_MIN_RST;
		band_hi = HEIGHT_MAX_RST;

		// Directed sequence; values in Q25.6, so 64 is one unit
		add_row(pt_fixed_row(0, 0, 0, '0));
		add_row(pt_fixed_row(C_MAX, C_MIN, HEIGHT_MIN_RST - 1, '0));
		add_row(pt_fixed_row(C_MIN, C_MAX, HEIGHT_MAX_RST + 1, '0));
		add_row(pt_fixed_row(320, 320, C_MIN, '0));
		add_row(pt_fixed_row(320, 320, C_MAX, '0));
		add_row(wr_row(0, 0, 0));
		add_row(wr_row(1, 640, 0));
		add_row(wr_row(2, 640, 640));
		add_row(wr_row(3, 0, 640));
		add_row(wr_row(4, 0, 0));
		add_row(reg_row(CFG_VERTEX_COUNT, 5));
		add_row(pt_row(320, 320, 0));
		add_row(pt_row(0, 320, HEIGHT_MIN_RST));
		add_row(pt_row(320, 0, HEIGHT_MAX_RST));
		add_row(pt_row(640, 640, 64));
		add_row(pt_row(1000, 320, 64));
		add_row(pt_fixed_row(320, 320, HEIGHT_MIN_RST - 1, '0));
		// empty height band
		add_row(reg_row(CFG_HEIGHT_MIN, 100));
		add_row(reg_row(CFG_HEIGHT_MAX, 50));
		add_row(pt_fixed_row(320, 320, 75, '0));
		add_row(reg_row(CFG_HEIGHT_MIN, C_MIN));
		add_row(reg_row(CFG_HEIGHT_MAX, C_MAX));
		add_row(pt_row(320, 320, C_MIN));
		// make both edges at slot 2 diagonal, then test a point on one
		add_row(wr_row(2, 1280, 1280));
		add_row(pt_row(960, 640, 0));
		// extreme vertex, and a count beyond the table depth
		add_row(wr_row(15, C_MAX, C_MIN));
		add_row(reg_row(CFG_VERTEX_COUNT, 31));
		add_row(pt_row(0, 0, 0));
		add_row(pt_row(C_MAX, C_MIN, C_MAX));
		// single vertex: no edge at all
		add_row(reg_row(CFG_VERTEX_COUNT, 1));
		add_row(pt_fixed_row(0, 0, 0, '0));
		add_row(reg_row(CFG_VERTEX_COUNT, 2));
		add_row(pt_row(320, 0, 0));
		add_row(reg_row(CFG_SPARE, 32'hA5C3_5A3C));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every slot so that no query ever reads an unwritten entry
		for (int s = 0; s < MAXV; s++)
			send_word(OP_WRITE, SLOT_W'(s), $urandom(), $urandom(), $urandom(), 1'b0, '0);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_reg) begin
				wait_idle();
				cfg_write(dir_rows[k].reg_idx, dir_rows[k].reg_data);
			end else begin
				send_word(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].x, dir_rows[k].z,
					dir_rows[k].y, dir_rows[k].fixed, dir_rows[k].fixed_ans);
			end
		end

		// Random phases: new registers, a fresh polygon, then point tests
		while (words_sent < WORD_GOAL) begin
			wait_idle();
			calm = ($urandom_range(0, 5) == 0);

			r = $urandom_range(0, 99);
			if (r < 20)
				cnt = MAXV;
			else if (r < 75)
				cnt = $urandom_range(4, MAXV);
			else if (r < 88)
				cnt = $urandom_range(0, 3);
			else
				cnt = $urandom_range(MAXV + 1, 31);
			data = $urandom();
			if ($urandom_range(0, 1) == 0)
				data[31:COUNT_W] = '0;
			data[COUNT_W-1:0] = COUNT_W'(cnt);
			cfg_write(CFG_VERTEX_COUNT, data);

			r = $urandom_range(0, 99);
			if (r < 50) begin
				hlo = HEIGHT_MIN_RST;
				hhi = HEIGHT_MAX_RST;
			end else if (r < 70) begin
				hlo = $urandom();
				hhi = hlo + $urandom_range(0, 1 << 20);
			end else if (r < 80) begin
				hlo = C_MIN;
				hhi = C_MAX;
			end else if (r < 90) begin
				hlo = 5000;
				hhi = hlo - $urandom_range(1, 1000);
			end else begin
				hlo = $urandom();
				hhi = $urandom();
			end
			cfg_write(CFG_HEIGHT_MIN, hlo);
			cfg_write(CFG_HEIGHT_MAX, hhi);
			if ($urandom_range(0, 9) == 0)
				cfg_write(CFG_SPARE, $urandom());

			// Build the polygon with the closing repeat of the first vertex
			n = (cnt > MAXV) ? MAXV : cnt;
			style = $urandom_range(0, 99);
			step = ($urandom_range(0, 1) == 0) ? longint'(64) : longint'($urandom_range(1, 4096));
			ox = longint'($urandom_range(0, 2097152)) - 1048576;
			oz = longint'($urandom_range(0, 2097152)) - 1048576;
			for (int i = 0; i < n; i++) begin
				if (i > 0 && i == n - 1) begin
					poly_x[i] = poly_x[0];
					poly_z[i] = poly_z[0];
				end else if (style < 60) begin
					if (i == 0) begin
						poly_x[i] = ox;
						poly_z[i] = oz;
					end else if (i >= 2 && i == n - 2) begin
						poly_x[i] = poly_x[0];
						poly_z[i] = poly_z[i - 1];
					end else if (i % 2 == 1) begin
						poly_x[i] = poly_x[i - 1] + step * (int'($urandom_range(0, 16)) - 8);
						poly_z[i] = poly_z[i - 1];
					end else begin
						poly_x[i] = poly_x[i - 1];
						poly_z[i] = poly_z[i - 1] + step * (int'($urandom_range(0, 16)) - 8);
					end
				end else if (style < 85) begin
					poly_x[i] = ox + step * (int'($urandom_range(0, 16)) - 8);
					poly_z[i] = oz + step * (int'($urandom_range(0, 16)) - 8);
				end else begin
					poly_x[i] = pick_extreme();
					poly_z[i] = pick_extreme();
				end
			end
			for (int i = 0; i < n; i++)
				send_word(OP_WRITE, SLOT_W'(i), poly_x[i][31:0], poly_z[i][31:0], $urandom(),
					1'b0, '0);

			nq = $urandom_range(10, 40);
			for (int k = 0; k < nq; k++) begin
				// Occasional stray vertex write breaks the polygon
				if ($urandom_range(0, 99) < 6) begin
					if ($urandom_range(0, 1) == 0)
						send_word(OP_WRITE, SLOT_W'($urandom_range(0, MAXV - 1)), $urandom(),
							$urandom(), $urandom(), 1'b0, '0);
					else
						send_word(OP_WRITE, SLOT_W'($urandom_range(0, MAXV - 1)),
							32'(ox + step * (int'($urandom_range(0, 16)) - 8)),
							32'(oz + step * (int'($urandom_range(0, 16)) - 8)),
							$urandom(), 1'b0, '0);
					continue;
				end

				r = (n == 0) ? 95 : $urandom_range(0, 99);
				if (r < 25 || (r < 55 && n < 2)) begin
					pi = $urandom_range(0, n - 1);
					ax = vtx_x[pi];
					az = vtx_z[pi];
				end else if (r < 55) begin
					pi = $urandom_range(0, n - 2);
					pj = pi + 1;
					x1 = vtx_x[pi];
					z1 = vtx_z[pi];
					x2 = vtx_x[pj];
					z2 = vtx_z[pj];
					if (x1 == x2) begin
						ax = x1;
						az = rand_between((z1 < z2) ? z1 : z2, (z1 < z2) ? z2 : z1);
					end else if (z1 == z2) begin
						az = z1;
						ax = rand_between((x1 < x2) ? x1 : x2, (x1 < x2) ? x2 : x1);
					end else begin
						ax = (x1 + x2) >>> 1;
						az = (z1 + z2) >>> 1;
					end
				end else if (r < 70) begin
					pi = $urandom_range(0, n - 1);
					off = int'($urandom_range(0, 2)) - 1;
					ax = vtx_x[pi] + (($urandom_range(0, 1) == 0) ? off : 64 * off);
					off = int'($urandom_range(0, 2)) - 1;
					az = vtx_z[pi] + (($urandom_range(0, 1) == 0) ? off : 64 * off);
				end else if (r < 90) begin
					lo_x = vtx_x[0];
					hi_x = vtx_x[0];
					lo_z = vtx_z[0];
					hi_z = vtx_z[0];
					for (int i = 1; i < n; i++) begin
						if (vtx_x[i] < lo_x) lo_x = vtx_x[i];
						if (vtx_x[i] > hi_x) hi_x = vtx_x[i];
						if (vtx_z[i] < lo_z) lo_z = vtx_z[i];
						if (vtx_z[i] > hi_z) hi_z = vtx_z[i];
					end
					ax = rand_between(lo_x, hi_x);
					az = rand_between(lo_z, hi_z);
				end else begin
					ax = sx($urandom());
					az = sx($urandom());
				end

				r = $urandom_range(0, 99);
				if (r < 70) begin
					data = (band_lo <= band_hi) ? 32'(rand_between(band_lo, band_hi))
						: $urandom();
				end else if (r < 85) begin
					case ($urandom_range(0, 3))
						0: data = band_lo;
						1: data = band_hi;
						2: data = band_lo - 1;
						default: data = band_hi + 1;
					endcase
				end else begin
					data = $urandom();
				end
				send_word(OP_TEST, SLOT_W'($urandom_range(0, MAXV - 1)), ax[31:0], az[31:0],
					data, 1'b0, '0);
			end
		end

		busy = 1'b1;
		wait_idle();
		$display("Ran %0d words: %0d point tests and %0d vertex writes, %0d register writes",
			words_sent, tests_sent, words_sent - tests_sent, reg_writes);
		$display("Checked %0d results: %0d inside the polygon, %0d on an axis-aligned edge",
			results_seen, inside_hits, border_hits);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ppbt_pkg.sv
hdl/ppbt_if.sv
hdl/polygon_point_and_border_test_core.sv
tb/tb_polygon_point_and_border_test_core.sv
